FILE: rtl/smc_pkg.sv
// ----------------------------------------------------------------------------
// smc_pkg: shared definitions for the sensor monitor controller
// Sizes, event kind and register index codes, reset values and the
// status record of the iterative duty divider.
// ----------------------------------------------------------------------------
package smc_pkg;

  // Ring of temperature edge stamps.
  localparam int RING_DEPTH = 334;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int STAMP_W    = 32;

  // PWM timing.
  localparam int PWM_PERIOD = 20;
  localparam int PHASE_W    = 5;
  localparam int DUTY_W     = 5;
  localparam int DUTY_MAX   = (PWM_PERIOD + 1 > 31) ? 31 : PWM_PERIOD + 1;
  localparam int DUTY_RESET = 10;

  // Light rescale: light * PWM_PERIOD divided by the full scale.
  localparam int LIGHT_W = 16;
  localparam int NUM_W   = LIGHT_W + $clog2(PWM_PERIOD + 1);
  localparam int CNT_W   = $clog2(NUM_W + 1);

  // Temperature conversion.
  localparam int TEMP_W      = 16;
  localparam int TEMP_OFFSET = 2731;
  localparam int TEMP_MAX    = 32767;

  // Seconds digit and the digits that rescale the duty.
  localparam int DIGIT_W    = 4;
  localparam int RESCALE_A  = 5;
  localparam int RESCALE_B  = 10;
  localparam int LAST_DIGIT = 15;

  // Accelerometer and configuration widths.
  localparam int ACCEL_W    = 8;
  localparam int LEVEL_W    = 9;
  localparam int SUM_W      = 11;
  localparam int REPORT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration reset values.
  localparam int REST_RESET = 64;
  localparam int BAND_RESET = 16;
  localparam int FULL_RESET = 3892;
  localparam int WARN_RESET = 450;

  // Event kinds carried by an input item.
  typedef enum logic [2:0] {
    KIND_TEMP   = 3'd0,
    KIND_SECOND = 3'd1,
    KIND_PWM    = 3'd2,
    KIND_TOGGLE = 3'd3,
    KIND_LIGHT  = 3'd4
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REST = 2'd0,
    REG_BAND = 2'd1,
    REG_FULL = 2'd2,
    REG_WARN = 2'd3
  } cfg_reg_e;

  // Status of the duty divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Advance a ring slot with wrap.
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] res;
    if (slot >= SLOT_W'(RING_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = slot + SLOT_W'(1);
    end
    return res;
  endfunction

endpackage

FILE: rtl/sensor_monitor_controller_unit.sv
// ----------------------------------------------------------------------------
// sensor_monitor_controller_unit: environment monitor, one status item per event
// Most events go straight to the output register; a temp edge reads the ring
// once it is full, then checks the warning; a rescale tick with a nonzero full
// scale runs the 21-step divider. One item is in work at a time, and a finished
// result waits in the output register until it is taken.
// Reset clears all status and configuration; the stamp ring needs no clearing.
// ----------------------------------------------------------------------------
module sensor_monitor_controller_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [smc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [smc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // Input channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [2:0]                           kind_i,
  input  logic [smc_pkg::STAMP_W-1:0]          timestamp_ms_i,
  input  logic signed [smc_pkg::ACCEL_W-1:0]   accel_x_i,
  input  logic signed [smc_pkg::ACCEL_W-1:0]   accel_y_i,
  input  logic signed [smc_pkg::ACCEL_W-1:0]   accel_z_i,
  input  logic [smc_pkg::LIGHT_W-1:0]          light_level_i,
  // Output channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 red_led_o,
  output logic                                 blue_led_o,
  output logic                                 red_alarm_o,
  output logic                                 blue_alarm_o,
  output logic [smc_pkg::DIGIT_W-1:0]          display_digit_o,
  output logic                                 motion_flag_o,
  output logic signed [smc_pkg::TEMP_W-1:0]    temperature_o,
  output logic [smc_pkg::DUTY_W-1:0]           pwm_duty_o,
  output logic                                 report_now_o,
  output logic [smc_pkg::REPORT_W-1:0]         report_number_o
);

  // Controller states.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_TEMP_RD  = 3'd1;
  localparam logic [2:0] ST_TEMP_CHK = 3'd2;
  localparam logic [2:0] ST_DIV      = 3'd3;
  localparam logic [2:0] ST_FINISH   = 3'd4;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [smc_pkg::LEVEL_W-1:0]       rest_q;
  logic [smc_pkg::LEVEL_W-1:0]       band_q;
  logic [smc_pkg::LIGHT_W-1:0]       full_q;
  logic signed [smc_pkg::TEMP_W-1:0] warn_q;

  // Monitor state.
  logic [smc_pkg::SLOT_W-1:0]        write_slot_q, write_slot_d;
  logic [smc_pkg::SLOT_W-1:0]        oldest_slot_q, oldest_slot_d;
  logic signed [smc_pkg::TEMP_W-1:0] temp_q, temp_d;
  logic [smc_pkg::DIGIT_W-1:0]       digit_q, digit_d;
  logic                              motion_q, motion_d;
  logic [1:0]                        alarm_q, alarm_d;
  logic [smc_pkg::DUTY_W-1:0]        duty_q, duty_d;
  logic [smc_pkg::PHASE_W-1:0]       phase_q, phase_d;
  logic                              leds_en_q, leds_en_d;
  logic [1:0]                        led_q, led_d;
  logic [smc_pkg::REPORT_W-1:0]      report_total_q, report_total_d;
  logic                              report_now_q, report_now_d;
  logic [smc_pkg::STAMP_W-1:0]       stamp_q, stamp_d;
  logic                              out_valid_q, out_valid_d;

  // Output payload registers.
  logic [1:0]                        out_led_q;
  logic [1:0]                        out_alarm_q;
  logic [smc_pkg::DIGIT_W-1:0]       out_digit_q;
  logic                              out_motion_q;
  logic signed [smc_pkg::TEMP_W-1:0] out_temp_q;
  logic [smc_pkg::DUTY_W-1:0]        out_duty_q;
  logic                              out_report_now_q;
  logic [smc_pkg::REPORT_W-1:0]      out_report_q;
  logic                              out_load;

  // Ring memory and divider hookup.
  logic                              ram_we;
  logic                              ram_re;
  logic [smc_pkg::SLOT_W-1:0]        ram_raddr;
  logic [smc_pkg::STAMP_W-1:0]       ram_rdata;
  logic                              div_start;
  logic [smc_pkg::NUM_W-1:0]         div_dividend;
  logic [smc_pkg::NUM_W-1:0]         div_quotient;
  smc_pkg::div_stat_t                div_stat;

  // Datapath helpers.
  logic                              in_fire;
  logic [smc_pkg::SLOT_W-1:0]        wr_next;
  logic [smc_pkg::STAMP_W-1:0]       span;
  logic [smc_pkg::STAMP_W+1:0]       scaled;
  logic [smc_pkg::ACCEL_W-1:0]       mag_x, mag_y, mag_z;
  logic [smc_pkg::SUM_W-1:0]         mag_sum;
  logic [smc_pkg::SUM_W-1:0]         band_hi;
  logic                              motion_now;
  logic [smc_pkg::PHASE_W:0]         phase_inc;
  logic [smc_pkg::PHASE_W-1:0]       phase_next;
  logic [smc_pkg::DIGIT_W-1:0]       digit_next;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign wr_next    = smc_pkg::next_slot(write_slot_q);
  assign ram_raddr  = smc_pkg::next_slot(oldest_slot_q);

  // Stamp ring storage.
  smc_ram #(
    .DEPTH (smc_pkg::RING_DEPTH),
    .WIDTH (smc_pkg::STAMP_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_next),
    .wdata_i (timestamp_ms_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Duty rescale divider.
  assign div_dividend = smc_pkg::NUM_W'(light_level_i) * smc_pkg::NUM_W'(smc_pkg::PWM_PERIOD);

  smc_duty_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (full_q),
    .stat_o     (div_stat),
    .quotient_o (div_quotient)
  );

  // Motion test: sum of axis magnitudes against the band around rest.
  always_comb begin
    mag_x = accel_x_i[smc_pkg::ACCEL_W-1] ?
            (~unsigned'(accel_x_i) + smc_pkg::ACCEL_W'(1)) : unsigned'(accel_x_i);
    mag_y = accel_y_i[smc_pkg::ACCEL_W-1] ?
            (~unsigned'(accel_y_i) + smc_pkg::ACCEL_W'(1)) : unsigned'(accel_y_i);
    mag_z = accel_z_i[smc_pkg::ACCEL_W-1] ?
            (~unsigned'(accel_z_i) + smc_pkg::ACCEL_W'(1)) : unsigned'(accel_z_i);
    mag_sum = smc_pkg::SUM_W'(mag_x) + smc_pkg::SUM_W'(mag_y) + smc_pkg::SUM_W'(mag_z);
    band_hi = smc_pkg::SUM_W'(rest_q) + smc_pkg::SUM_W'(band_q);
    motion_now = (mag_sum > band_hi) ||
                 ((mag_sum + smc_pkg::SUM_W'(band_q)) < smc_pkg::SUM_W'(rest_q));
  end

  // Temperature from the span over the full ring.
  always_comb begin
    span   = stamp_q - ram_rdata;
    scaled = {2'b00, span} + {1'b0, span, 1'b0};
  end

  // PWM phase advance and seconds digit advance.
  always_comb begin
    phase_inc  = {1'b0, phase_q} + (smc_pkg::PHASE_W + 1)'(1);
    phase_next = (phase_inc >= (smc_pkg::PHASE_W + 1)'(smc_pkg::PWM_PERIOD)) ?
                 '0 : phase_inc[smc_pkg::PHASE_W-1:0];
    digit_next = (digit_q >= smc_pkg::DIGIT_W'(smc_pkg::LAST_DIGIT)) ?
                 '0 : digit_q + smc_pkg::DIGIT_W'(1);
  end

  // Main controller.
  always_comb begin
    state_d        = state_q;
    write_slot_d   = write_slot_q;
    oldest_slot_d  = oldest_slot_q;
    temp_d         = temp_q;
    digit_d        = digit_q;
    motion_d       = motion_q;
    alarm_d        = alarm_q;
    duty_d         = duty_q;
    phase_d        = phase_q;
    leds_en_d      = leds_en_q;
    led_d          = led_q;
    report_total_d = report_total_q;
    report_now_d   = report_now_q;
    stamp_d        = stamp_q;
    out_valid_d    = out_valid_q;
    out_load       = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    div_start      = 1'b0;

    // The waiting result leaves when taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          report_now_d = 1'b0;
          state_d      = ST_FINISH;
          case (smc_pkg::kind_e'(kind_i))
            smc_pkg::KIND_TEMP: begin
              // Store the stamp; once the ring is full, read the oldest one.
              ram_we       = 1'b1;
              write_slot_d = wr_next;
              stamp_d      = timestamp_ms_i;
              if (wr_next == oldest_slot_q) begin
                ram_re        = 1'b1;
                oldest_slot_d = ram_raddr;
                state_d       = ST_TEMP_RD;
              end else begin
                state_d = ST_TEMP_CHK;
              end
            end
            smc_pkg::KIND_SECOND: begin
              digit_d  = digit_next;
              motion_d = motion_now;
              if (digit_next inside {smc_pkg::DIGIT_W'(smc_pkg::RESCALE_A),
                                     smc_pkg::DIGIT_W'(smc_pkg::RESCALE_B),
                                     smc_pkg::DIGIT_W'(smc_pkg::LAST_DIGIT)}) begin
                write_slot_d  = smc_pkg::SLOT_W'(smc_pkg::RING_DEPTH - 1);
                oldest_slot_d = smc_pkg::SLOT_W'(smc_pkg::RING_DEPTH - 1);
                if (digit_next == smc_pkg::DIGIT_W'(smc_pkg::LAST_DIGIT)) begin
                  report_total_d = report_total_q + smc_pkg::REPORT_W'(1);
                  report_now_d   = 1'b1;
                end
                if (full_q == '0) begin
                  duty_d = smc_pkg::DUTY_W'(smc_pkg::DUTY_MAX);
                end else begin
                  div_start = 1'b1;
                  state_d   = ST_DIV;
                end
              end
            end
            smc_pkg::KIND_PWM: begin
              if (leds_en_q) begin
                phase_d = phase_next;
                if ((phase_next == '0) && (duty_q != '0)) begin
                  led_d = alarm_q;
                end
                if (phase_next == duty_q) begin
                  led_d = '0;
                end
              end
            end
            smc_pkg::KIND_TOGGLE: begin
              leds_en_d = !leds_en_q;
              if (!leds_en_q) begin
                phase_d = smc_pkg::PHASE_W'(smc_pkg::PWM_PERIOD - 1);
              end else begin
                led_d = '0;
              end
            end
            smc_pkg::KIND_LIGHT: begin
              if (motion_q) begin
                alarm_d[1] = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_TEMP_RD: begin
        // Saturate span*3 - offset at the top of the 16-bit range.
        if (scaled > (smc_pkg::STAMP_W + 2)'(smc_pkg::TEMP_OFFSET + smc_pkg::TEMP_MAX)) begin
          temp_d = smc_pkg::TEMP_W'(smc_pkg::TEMP_MAX);
        end else begin
          temp_d = smc_pkg::TEMP_W'(scaled - (smc_pkg::STAMP_W + 2)'(smc_pkg::TEMP_OFFSET));
        end
        state_d = ST_TEMP_CHK;
      end

      ST_TEMP_CHK: begin
        if (temp_q > warn_q) begin
          alarm_d[0] = 1'b1;
        end
        state_d = ST_FINISH;
      end

      ST_DIV: begin
        if (div_stat.done) begin
          if (div_quotient >= smc_pkg::NUM_W'(smc_pkg::DUTY_MAX)) begin
            duty_d = smc_pkg::DUTY_W'(smc_pkg::DUTY_MAX);
          end else begin
            duty_d = div_quotient[smc_pkg::DUTY_W-1:0] + smc_pkg::DUTY_W'(1);
          end
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // Hand the status to the output register once it is free.
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and status registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      write_slot_q   <= smc_pkg::SLOT_W'(smc_pkg::RING_DEPTH - 1);
      oldest_slot_q  <= smc_pkg::SLOT_W'(smc_pkg::RING_DEPTH - 1);
      temp_q         <= '0;
      digit_q        <= '0;
      motion_q       <= 1'b0;
      alarm_q        <= '0;
      duty_q         <= smc_pkg::DUTY_W'(smc_pkg::DUTY_RESET);
      phase_q        <= '0;
      leds_en_q      <= 1'b0;
      led_q          <= '0;
      report_total_q <= '0;
      report_now_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      write_slot_q   <= write_slot_d;
      oldest_slot_q  <= oldest_slot_d;
      temp_q         <= temp_d;
      digit_q        <= digit_d;
      motion_q       <= motion_d;
      alarm_q        <= alarm_d;
      duty_q         <= duty_d;
      phase_q        <= phase_d;
      leds_en_q      <= leds_en_d;
      led_q          <= led_d;
      report_total_q <= report_total_d;
      report_now_q   <= report_now_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= smc_pkg::LEVEL_W'(smc_pkg::REST_RESET);
      band_q <= smc_pkg::LEVEL_W'(smc_pkg::BAND_RESET);
      full_q <= smc_pkg::LIGHT_W'(smc_pkg::FULL_RESET);
      warn_q <= smc_pkg::TEMP_W'(smc_pkg::WARN_RESET);
    end else if (cfg_we_i) begin
      case (smc_pkg::cfg_reg_e'(cfg_index_i))
        smc_pkg::REG_REST: rest_q <= cfg_data_i[smc_pkg::LEVEL_W-1:0];
        smc_pkg::REG_BAND: band_q <= cfg_data_i[smc_pkg::LEVEL_W-1:0];
        smc_pkg::REG_FULL: full_q <= cfg_data_i[smc_pkg::LIGHT_W-1:0];
        smc_pkg::REG_WARN: warn_q <= signed'(cfg_data_i[smc_pkg::TEMP_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Stamp of the item in work and the output payload.
  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
    if (out_load) begin
      out_led_q        <= led_q;
      out_alarm_q      <= alarm_q;
      out_digit_q      <= digit_q;
      out_motion_q     <= motion_q;
      out_temp_q       <= temp_q;
      out_duty_q       <= duty_q;
      out_report_now_q <= report_now_q;
      out_report_q     <= report_total_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign red_led_o       = out_led_q[0];
  assign blue_led_o      = out_led_q[1];
  assign red_alarm_o     = out_alarm_q[0];
  assign blue_alarm_o    = out_alarm_q[1];
  assign display_digit_o = out_digit_q;
  assign motion_flag_o   = out_motion_q;
  assign temperature_o   = out_temp_q;
  assign pwm_duty_o      = out_duty_q;
  assign report_now_o    = out_report_now_q;
  assign report_number_o = out_report_q;

  // Ring pointers always stay inside the ring.
  a_slots_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (write_slot_q < smc_pkg::SLOT_W'(smc_pkg::RING_DEPTH)) &&
    (oldest_slot_q < smc_pkg::SLOT_W'(smc_pkg::RING_DEPTH)))
    else $error("ring slot out of range");

  // The divider only runs while the controller waits for it.
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == ST_DIV))
    else $error("divider busy outside of the rescale state");

  // A reported duty is always a legal step count.
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((pwm_duty_o != '0) &&
                     (pwm_duty_o <= smc_pkg::DUTY_W'(smc_pkg::DUTY_MAX))))
    else $error("pwm duty out of range");

  // A report is raised only on the last seconds digit.
  a_report_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && report_now_o) |->
      (display_digit_o == smc_pkg::DIGIT_W'(smc_pkg::LAST_DIGIT)))
    else $error("report raised away from the last digit");

endmodule

FILE: rtl/smc_ram.sv
// ----------------------------------------------------------------------------
// smc_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smc_ram #(
  parameter int DEPTH = 334,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered on a read enable.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/smc_duty_div.sv
// ----------------------------------------------------------------------------
// smc_duty_div: iterative restoring divider for the duty rescale
// Produces one quotient bit per cycle, NUM_W steps per division.
// ----------------------------------------------------------------------------
module smc_duty_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [smc_pkg::NUM_W-1:0]    dividend_i,
  input  logic [smc_pkg::LIGHT_W-1:0]  divisor_i,
  output smc_pkg::div_stat_t           stat_o,
  output logic [smc_pkg::NUM_W-1:0]    quotient_o
);

  logic                         busy_q, busy_d;
  logic [smc_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [smc_pkg::NUM_W-1:0]    quo_q, quo_d;
  logic [smc_pkg::LIGHT_W-1:0]  rem_q, rem_d;
  logic [smc_pkg::LIGHT_W-1:0]  dvs_q, dvs_d;
  logic [smc_pkg::LIGHT_W:0]    trial;
  logic [smc_pkg::LIGHT_W:0]    diff;
  logic                         fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_q, quo_q[smc_pkg::NUM_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});

    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = smc_pkg::CNT_W'(smc_pkg::NUM_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        quo_d = {quo_q[smc_pkg::NUM_W-2:0], fits};
        rem_d = fits ? diff[smc_pkg::LIGHT_W-1:0] : trial[smc_pkg::LIGHT_W-1:0];
        cnt_d = cnt_q - smc_pkg::CNT_W'(1);
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == '0);
  assign quotient_o  = quo_q;

endmodule

FILE: sim/sensor_monitor_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// sensor_monitor_controller_unit_tb: self-checking bench for the monitor
// Walks a short table of hand-picked events, then long random runs. Temperature
// runs fill the stamp ring so spans turn into readings; mixed runs cover
// seconds, PWM, toggles and light interrupts. Every status item is compared
// field by field with its table entry or a predictor of block state and registers.
// ----------------------------------------------------------------------------
module sensor_monitor_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smc_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 6;
  localparam int IDLE_PCT     = 13;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 40;
  localparam int TEMP_SCALE   = 3;
  localparam int AXIS_MAX     = 127;
  localparam int SUM_LIMIT    = 3 * AXIS_MAX;

  // Kinds that the block leaves without effect.
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_MID   = 3'd6;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0]         kind;
    logic [STAMP_W-1:0] stamp;
    logic [ACCEL_W-1:0] ax;
    logic [ACCEL_W-1:0] ay;
    logic [ACCEL_W-1:0] az;
    logic [LIGHT_W-1:0] light;
  } sensor_event_t;

  typedef struct packed {
    logic                red_led;
    logic                blue_led;
    logic                red_alarm;
    logic                blue_alarm;
    logic [DIGIT_W-1:0]  digit;
    logic                motion;
    logic [TEMP_W-1:0]   temp;
    logic [DUTY_W-1:0]   duty;
    logic                report_now;
    logic [REPORT_W-1:0] report_number;
  } status_t;

  typedef struct {
    sensor_event_t ev;
    bit            typed;
    status_t       want;
  } stim_row_t;

  // Clock, reset and block inputs, all known from time zero.
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic [2:0]            kind_i         = '0;
  logic [STAMP_W-1:0]    timestamp_ms_i = '0;
  logic [ACCEL_W-1:0]    accel_x_i      = '0;
  logic [ACCEL_W-1:0]    accel_y_i      = '0;
  logic [ACCEL_W-1:0]    accel_z_i      = '0;
  logic [LIGHT_W-1:0]    light_level_i  = '0;
  logic                  out_ready_i    = 1'b0;

  logic                  in_ready_o;
  logic                  out_valid_o;
  logic                  red_led_o;
  logic                  blue_led_o;
  logic                  red_alarm_o;
  logic                  blue_alarm_o;
  logic [DIGIT_W-1:0]    display_digit_o;
  logic                  motion_flag_o;
  logic [TEMP_W-1:0]     temperature_o;
  logic [DUTY_W-1:0]     pwm_duty_o;
  logic                  report_now_o;
  logic [REPORT_W-1:0]   report_number_o;

  // Predicted configuration, starting from the reset values.
  logic [LEVEL_W-1:0]       rest_cfg = LEVEL_W'(REST_RESET);
  logic [LEVEL_W-1:0]       band_cfg = LEVEL_W'(BAND_RESET);
  logic [LIGHT_W-1:0]       full_cfg = LIGHT_W'(FULL_RESET);
  logic signed [TEMP_W-1:0] warn_cfg = TEMP_W'(WARN_RESET);

  // Predicted monitor state, starting from the reset values.
  logic [STAMP_W-1:0]       stamp_mem [RING_DEPTH];
  logic [SLOT_W-1:0]        wr_slot  = SLOT_W'(RING_DEPTH - 1);
  logic [SLOT_W-1:0]        rd_slot  = SLOT_W'(RING_DEPTH - 1);
  logic signed [TEMP_W-1:0] temp_q   = '0;
  logic [DIGIT_W-1:0]       digit_q  = '0;
  logic                     motion_q = 1'b0;
  logic [1:0]               alarm_q  = '0;
  logic [DUTY_W-1:0]        duty_q   = DUTY_W'(DUTY_RESET);
  logic [PHASE_W-1:0]       phase_q  = '0;
  logic                     leds_on  = 1'b0;
  logic [1:0]               drive_q  = '0;
  logic [REPORT_W-1:0]      reports_q = '0;

  status_t   pending_status [$];
  stim_row_t directed_rows [$];
  bit        row_typed = 1'b0;
  status_t   row_want  = '0;
  bit        no_gaps   = 1'b0;
  int        fail_count   = 0;
  int        quiet_cycles = 0;

  sensor_monitor_controller_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .timestamp_ms_i  (timestamp_ms_i),
    .accel_x_i       (accel_x_i),
    .accel_y_i       (accel_y_i),
    .accel_z_i       (accel_z_i),
    .light_level_i   (light_level_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_led_o       (red_led_o),
    .blue_led_o      (blue_led_o),
    .red_alarm_o     (red_alarm_o),
    .blue_alarm_o    (blue_alarm_o),
    .display_digit_o (display_digit_o),
    .motion_flag_o   (motion_flag_o),
    .temperature_o   (temperature_o),
    .pwm_duty_o      (pwm_duty_o),
    .report_now_o    (report_now_o),
    .report_number_o (report_number_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // The result side stalls at random except during the steady stretch.
  always @(negedge clk_i) begin
    out_ready_i <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic int mag8(input logic [ACCEL_W-1:0] v);
    int s;
    s = int'($signed(v));
    return (s < 0) ? -s : s;
  endfunction

  function automatic sensor_event_t ev_of(input logic [2:0] kind,
                                          input logic [STAMP_W-1:0] stamp,
                                          input logic [ACCEL_W-1:0] ax,
                                          input logic [ACCEL_W-1:0] ay,
                                          input logic [ACCEL_W-1:0] az,
                                          input logic [LIGHT_W-1:0] light);
    sensor_event_t ev;
    ev.kind  = kind;
    ev.stamp = stamp;
    ev.ax    = ax;
    ev.ay    = ay;
    ev.az    = az;
    ev.light = light;
    return ev;
  endfunction

  // Applies one event to the predicted state and returns the status it shows.
  task automatic update_status(input sensor_event_t ev, output status_t st);
    logic [STAMP_W-1:0] span;
    longint             reading;
    int                 sum;
    int                 hi;
    int                 lo;
    int unsigned        duty;
    logic               raised;
    raised = 1'b0;
    case (ev.kind)
      KIND_TEMP: begin
        wr_slot = (wr_slot >= SLOT_W'(RING_DEPTH - 1)) ? '0 : wr_slot + 1'b1;
        stamp_mem[wr_slot] = ev.stamp;
        // A full ring gives the span over all stored periods.
        if (wr_slot == rd_slot) begin
          rd_slot = (rd_slot >= SLOT_W'(RING_DEPTH - 1)) ? '0 : rd_slot + 1'b1;
          span = stamp_mem[wr_slot] - stamp_mem[rd_slot];
          reading = longint'(span) * TEMP_SCALE - TEMP_OFFSET;
          if (reading > TEMP_MAX) begin
            reading = TEMP_MAX;
          end
          temp_q = TEMP_W'(reading);
        end
        if (temp_q > warn_cfg) begin
          alarm_q[0] = 1'b1;
        end
      end
      KIND_SECOND: begin
        digit_q = (digit_q >= DIGIT_W'(LAST_DIGIT)) ? '0 : digit_q + 1'b1;
        sum = mag8(ev.ax) + mag8(ev.ay) + mag8(ev.az);
        hi = int'(rest_cfg) + int'(band_cfg);
        lo = int'(rest_cfg) - int'(band_cfg);
        motion_q = (sum > hi) || (sum < lo);
        // Rescale digits reload the duty and restart the ring.
        if (digit_q == RESCALE_A || digit_q == RESCALE_B || digit_q == LAST_DIGIT) begin
          if (full_cfg == '0) begin
            duty = DUTY_MAX;
          end else begin
            duty = (32'(ev.light) * PWM_PERIOD) / full_cfg + 1;
            if (duty > DUTY_MAX) begin
              duty = DUTY_MAX;
            end
          end
          duty_q = DUTY_W'(duty);
          if (digit_q == LAST_DIGIT) begin
            reports_q = reports_q + 1'b1;
            raised = 1'b1;
          end
          wr_slot = SLOT_W'(RING_DEPTH - 1);
          rd_slot = SLOT_W'(RING_DEPTH - 1);
        end
      end
      KIND_PWM: begin
        if (leds_on) begin
          phase_q = phase_q + 1'b1;
          if (phase_q >= PWM_PERIOD) begin
            phase_q = '0;
          end
          if (phase_q == '0 && duty_q != '0) begin
            drive_q = alarm_q;
          end
          if (phase_q == duty_q) begin
            drive_q = '0;
          end
        end
      end
      KIND_TOGGLE: begin
        leds_on = ~leds_on;
        if (leds_on) begin
          phase_q = PHASE_W'(PWM_PERIOD - 1);
        end else begin
          drive_q = '0;
        end
      end
      KIND_LIGHT: begin
        if (motion_q) begin
          alarm_q[1] = 1'b1;
        end
      end
      default: begin
      end
    endcase
    st.red_led       = drive_q[0];
    st.blue_led      = drive_q[1];
    st.red_alarm     = alarm_q[0];
    st.blue_alarm    = alarm_q[1];
    st.digit         = digit_q;
    st.motion        = motion_q;
    st.temp          = temp_q;
    st.duty          = duty_q;
    st.report_now    = raised;
    st.report_number = reports_q;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic compare_status(input status_t want, input status_t got);
    check_field("red_led", want.red_led, got.red_led);
    check_field("blue_led", want.blue_led, got.blue_led);
    check_field("red_alarm", want.red_alarm, got.red_alarm);
    check_field("blue_alarm", want.blue_alarm, got.blue_alarm);
    check_field("display_digit", want.digit, got.digit);
    check_field("motion_flag", want.motion, got.motion);
    check_field("temperature", int'($signed(want.temp)), int'($signed(got.temp)));
    check_field("pwm_duty", want.duty, got.duty);
    check_field("report_now", want.report_now, got.report_now);
    check_field("report_number", want.report_number, got.report_number);
  endtask

  // Watches both channels and the register port at every rising edge.
  always @(posedge clk_i) begin
    status_t predicted;
    status_t got;
    status_t want;
    bit      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_REST: rest_cfg = cfg_data_i[LEVEL_W-1:0];
          REG_BAND: band_cfg = cfg_data_i[LEVEL_W-1:0];
          REG_FULL: full_cfg = cfg_data_i;
          REG_WARN: warn_cfg = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        update_status(ev_of(kind_i, timestamp_ms_i, accel_x_i, accel_y_i, accel_z_i,
                            light_level_i), predicted);
        pending_status.push_back(row_typed ? row_want : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        got.red_led       = red_led_o;
        got.blue_led      = blue_led_o;
        got.red_alarm     = red_alarm_o;
        got.blue_alarm    = blue_alarm_o;
        got.digit         = display_digit_o;
        got.motion        = motion_flag_o;
        got.temp          = temperature_o;
        got.duty          = pwm_duty_o;
        got.report_now    = report_now_o;
        got.report_number = report_number_o;
        if (pending_status.size() == 0) begin
          fail_count++;
          $display("%0t: result with no item pending, expected none, got %p", $time, got);
        end else begin
          want = pending_status.pop_front();
          compare_status(want, got);
        end
      end
      // Watchdog on cycles in which neither channel moves.
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offers one item and holds it until the block takes it.
  task automatic push_event(input sensor_event_t ev, input bit typed, input status_t want);
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    row_typed = typed;
    row_want  = want;
    kind_i         <= ev.kind;
    timestamp_ms_i <= ev.stamp;
    accel_x_i      <= ev.ax;
    accel_y_i      <= ev.ay;
    accel_z_i      <= ev.az;
    light_level_i  <= ev.light;
    in_valid_i     <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
  endtask

  // Stops offering items until every pending result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] rest,
                              input logic [CFG_DATA_W-1:0] band,
                              input logic [CFG_DATA_W-1:0] full,
                              input logic [CFG_DATA_W-1:0] warn);
    cfg_reg_e              regs [4] = '{REG_REST, REG_BAND, REG_FULL, REG_WARN};
    logic [CFG_DATA_W-1:0] vals [4];
    vals = '{rest, band, full, warn};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random event with a bias toward seconds ticks whose axis sum sits near
  // the edges of the rest band.
  task automatic random_event(output sensor_event_t ev);
    int pick;
    int target;
    int a;
    int b;
    int c;
    ev.kind  = KIND_PWM;
    ev.stamp = $urandom;
    ev.ax    = ACCEL_W'($urandom);
    ev.ay    = ACCEL_W'($urandom);
    ev.az    = ACCEL_W'($urandom);
    case ($urandom_range(7))
      0: ev.light = '0;
      1: ev.light = '1;
      default: ev.light = LIGHT_W'($urandom);
    endcase
    pick = $urandom_range(99);
    if (pick < 35) begin
      ev.kind = KIND_SECOND;
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(4))
          0: target = int'(rest_cfg) - int'(band_cfg) - 1;
          1: target = int'(rest_cfg) - int'(band_cfg);
          2: target = int'(rest_cfg) + int'(band_cfg);
          3: target = int'(rest_cfg) + int'(band_cfg) + 1;
          default: target = int'(rest_cfg) - int'(band_cfg)
                            + int'($urandom_range(2 * band_cfg));
        endcase
        if (target < 0) begin
          target = 0;
        end
        if (target > SUM_LIMIT) begin
          target = SUM_LIMIT;
        end
        // Split the target sum over the three axes with random signs.
        a = $urandom_range((target > AXIS_MAX) ? AXIS_MAX : target,
                           (target > 2 * AXIS_MAX) ? target - 2 * AXIS_MAX : 0);
        c = target - a;
        b = $urandom_range((c > AXIS_MAX) ? AXIS_MAX : c, (c > AXIS_MAX) ? c - AXIS_MAX : 0);
        c = c - b;
        ev.ax = ($urandom_range(1) == 1) ? ACCEL_W'(-a) : ACCEL_W'(a);
        ev.ay = ($urandom_range(1) == 1) ? ACCEL_W'(-b) : ACCEL_W'(b);
        ev.az = ($urandom_range(1) == 1) ? ACCEL_W'(-c) : ACCEL_W'(c);
      end
    end else if (pick < 65) begin
      ev.kind = KIND_PWM;
    end else if (pick < 75) begin
      ev.kind = KIND_TEMP;
    end else if (pick < 85) begin
      ev.kind = KIND_LIGHT;
    end else if (pick < 93) begin
      ev.kind = KIND_TOGGLE;
    end else begin
      ev.kind = 3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
    end
  endtask

  task automatic mixed_run(input int count);
    sensor_event_t ev;
    for (int i = 0; i < count; i++) begin
      random_event(ev);
      push_event(ev, 1'b0, '0);
      if ($urandom_range(39) == 0) begin
        drain_results();
      end
    end
  endtask

  // A run of rising stamps long enough to fill the ring about once over, then
  // take readings. Sparse noise never clears the ring.
  task automatic temp_run(input int count, input logic [STAMP_W-1:0] base,
                          input int inc_lo, input int inc_hi);
    sensor_event_t      ev;
    logic [STAMP_W-1:0] stamp;
    logic [DIGIT_W-1:0] dig;
    logic [DIGIT_W-1:0] next_dig;
    stamp = base;
    dig   = digit_q;
    for (int i = 0; i < count; i++) begin
      random_event(ev);
      if ($urandom_range(19) == 0) begin
        next_dig = (dig >= DIGIT_W'(LAST_DIGIT)) ? '0 : dig + 1'b1;
        if (ev.kind == KIND_TEMP) begin
          ev.kind = KIND_PWM;
        end
        if (ev.kind == KIND_SECOND) begin
          if (next_dig == RESCALE_A || next_dig == RESCALE_B || next_dig == LAST_DIGIT) begin
            ev.kind = KIND_LIGHT;
          end else begin
            dig = next_dig;
          end
        end
      end else begin
        stamp    = stamp + $urandom_range(inc_hi, inc_lo);
        ev.kind  = KIND_TEMP;
        ev.stamp = stamp;
      end
      push_event(ev, 1'b0, '0);
    end
  endtask

  initial begin
    status_t st_reset;
    status_t st_moved;
    status_t st_blue;
    st_reset      = '0;
    st_reset.duty = DUTY_W'(DUTY_RESET);
    st_moved        = st_reset;
    st_moved.digit  = DIGIT_W'(1);
    st_moved.motion = 1'b1;
    st_blue            = st_moved;
    st_blue.blue_alarm = 1'b1;

    // Directed table: spare kinds, ignored events, field extremes, motion
    // band edges, a rescale with a saturated duty and the LED toggle.
    directed_rows = '{
      '{ev_of(KIND_SPARE_FIRST, '0, '0, '0, '0, '0), 1'b1, st_reset},
      '{ev_of(KIND_SPARE_LAST, '1, '1, '1, '1, '1), 1'b1, st_reset},
      '{ev_of(KIND_PWM, '0, '0, '0, '0, '0), 1'b1, st_reset},
      '{ev_of(KIND_LIGHT, '0, '0, '0, '0, '0), 1'b1, st_reset},
      '{ev_of(KIND_TEMP, 32'h0000_0000, '0, '0, '0, '0), 1'b1, st_reset},
      '{ev_of(KIND_TEMP, 32'hFFFF_FFFF, '0, '0, '0, '0), 1'b1, st_reset},
      '{ev_of(KIND_SECOND, '0, 8'h00, 8'h00, 8'h00, 16'h0000), 1'b1, st_moved},
      '{ev_of(KIND_LIGHT, '0, '0, '0, '0, '0), 1'b1, st_blue},
      '{ev_of(KIND_TOGGLE, '0, '0, '0, '0, '0), 1'b1, st_blue},
      '{ev_of(KIND_PWM, '0, '0, '0, '0, '0), 1'b0, '0},
      '{ev_of(KIND_PWM, '0, '0, '0, '0, '0), 1'b0, '0},
      '{ev_of(KIND_SPARE_MID, 32'h5555_5555, '0, '0, '0, '0), 1'b0, '0},
      '{ev_of(KIND_SECOND, '0, 8'h80, 8'h80, 8'h80, 16'hFFFF), 1'b0, '0},
      '{ev_of(KIND_SECOND, '1, 8'h7F, 8'h7F, 8'h7F, 16'h0000), 1'b0, '0},
      '{ev_of(KIND_SECOND, '0, 8'd40, 8'hEC, 8'd4, 16'h0001), 1'b0, '0},
      '{ev_of(KIND_SECOND, '0, 8'd48, 8'h00, 8'h00, 16'hFFFF), 1'b0, '0},
      '{ev_of(KIND_SECOND, '0, 8'd80, 8'h00, 8'h00, 16'h0000), 1'b0, '0},
      '{ev_of(KIND_SECOND, '0, 8'd81, 8'h00, 8'h00, 16'h0000), 1'b0, '0},
      '{ev_of(KIND_LIGHT, '0, '0, '0, '0, '0), 1'b0, '0},
      '{ev_of(KIND_TOGGLE, '0, '0, '0, '0, '0), 1'b0, '0},
      '{ev_of(KIND_PWM, '0, '0, '0, '0, '0), 1'b0, '0},
      '{ev_of(KIND_TEMP, 32'h5555_5555, '0, '0, '0, '0), 1'b0, '0},
      '{ev_of(KIND_TEMP, 32'hAAAA_AAAA, '0, '0, '0, '0), 1'b0, '0},
      '{ev_of(KIND_TOGGLE, '0, '0, '0, '0, '0), 1'b0, '0}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      push_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
    end

    // Widest band: no motion can be flagged; light spreads over the whole duty range.
    drain_results();
    program_regs(16'd384, 16'd384, 16'hFFFF, 16'sd32767);
    mixed_run(110);

    // Long periods drive the reading into saturation.
    drain_results();
    program_regs(16'd64, 16'd16, 16'd1, 16'sd32767);
    temp_run(400, $urandom, 25, 50);

    // Zero band and zero full scale.
    drain_results();
    program_regs(16'd0, 16'd0, 16'd0, 16'sd32767);
    mixed_run(110);

    // Room temperature readings around a random warning level, no stalls.
    drain_results();
    program_regs(16'($urandom_range(384)), 16'($urandom_range(48)),
                 16'($urandom_range(8000, 500)), 16'($urandom_range(400, 100)));
    no_gaps = 1'b1;
    temp_run(400, $urandom, 2, 4);
    no_gaps = 1'b0;

    drain_results();
    program_regs(16'($urandom_range(384)), 16'($urandom_range(64)),
                 16'($urandom_range(65535, 1)), 16'($urandom));
    mixed_run(110);

    // Stamps wrap through zero; cold readings against a warning at the coldest reading.
    drain_results();
    program_regs(16'd64, 16'd16, 16'd3892, 16'(-TEMP_OFFSET));
    temp_run(400, 32'hFFFF_FF00, 0, 2);

    drain_results();
    program_regs(16'($urandom_range(384)), 16'($urandom_range(64)),
                 16'($urandom_range(65535, 1)), 16'h8000);
    mixed_run(110);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
